>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, sampled on i_clk with the synchronous i_rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define KVT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("kvt assertion failed");

// checked on every edge, reset included
`define KVT_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("kvt assertion failed");

`endif

>>> hw/rtl/kvt_pkg.sv
// ----------------------------------------------------------------------------
// kvt_pkg
// shared constants, codes and types of the linear key/value table
// ----------------------------------------------------------------------------
`default_nettype none

package kvt_pkg;

    localparam int unsigned DEF_TABLE_DEPTH = 16;

    localparam int unsigned KEY_W     = 64;
    localparam int unsigned VAL_W     = 64;
    localparam int unsigned OP_W      = 2;
    localparam int unsigned ST_W      = 3;
    localparam int unsigned CNT_OUT_W = 5;

    localparam int unsigned S_TDATA_W = 128;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 72;
    localparam int unsigned M_TUSER_W = 3;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [ST_W-1:0] ST_REPLACED  = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
    localparam logic [ST_W-1:0] ST_REMOVED   = 3'd3;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [ST_W-1:0] ST_FOUND     = 3'd5;

    typedef struct packed {
        logic [ST_W-1:0]      status;
        logic [VAL_W-1:0]     found_value;
        logic [CNT_OUT_W-1:0] live_count;
    } t_result;

endpackage

`default_nettype wire

>>> hw/rtl/linear_key_value_table_unit.sv
// flow: an accepted item is scanned against the live entries, the key memory
//   read port delivering one entry per cycle, then acted on (a remove that
//   hits also moves the tail entry into the freed slot) and registered out;
//   a new item is taken only once the last result has left the controller
// reset: i_rst_n synchronous active low empties the table and drops tvalid;
//   memory contents are left as they are and never read before written
// ----------------------------------------------------------------------------
// linear_key_value_table_unit
// bounded key/value table with linear search, add/replace, remove, find
// ----------------------------------------------------------------------------
`default_nettype none

module linear_key_value_table_unit
    import kvt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // request items
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,   // lookup_key, new_value
    input  wire logic [S_TUSER_W-1:0] s_axis_tuser,   // operation
    // result items
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [M_TDATA_W-1:0] m_axis_tdata,   // found_value, live_count, pad
    output logic      [M_TUSER_W-1:0] m_axis_tuser    // status
);

    // index width of the memories, count width able to hold the depth itself
    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

    // controller to memory wiring
    logic             key_we;
    logic             val_we;
    logic [IDX_W-1:0] waddr;
    logic [KEY_W-1:0] wkey;
    logic [VAL_W-1:0] wval;
    logic [IDX_W-1:0] raddr;
    logic [KEY_W-1:0] rkey;
    logic [VAL_W-1:0] rval;

    // controller response and output register
    logic    rsp_valid;
    logic    rsp_ready;
    t_result rsp;
    logic    r_out_valid;
    t_result r_out;

    kvt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_op        (s_axis_tuser[OP_W-1:0]),
        .i_key       (s_axis_tdata[KEY_W-1:0]),
        .i_value     (s_axis_tdata[KEY_W +: VAL_W]),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp),
        .o_key_we    (key_we),
        .o_val_we    (val_we),
        .o_waddr     (waddr),
        .o_wkey      (wkey),
        .o_wval      (wval),
        .o_raddr     (raddr),
        .i_rkey      (rkey),
        .i_rval      (rval)
    );

    // key and value memories share addresses, read in lockstep
    kvt_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (KEY_W),
        .AW    (IDX_W)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (waddr),
        .i_wdata (wkey),
        .i_raddr (raddr),
        .o_rdata (rkey)
    );

    kvt_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (VAL_W),
        .AW    (IDX_W)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (waddr),
        .i_wdata (wval),
        .i_raddr (raddr),
        .o_rdata (rval)
    );

    // output register: takes a result when empty or being drained
    assign rsp_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rsp_ready) begin
            r_out_valid <= rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rsp_ready && rsp_valid) begin
            r_out <= rsp;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {
        (M_TDATA_W - VAL_W - CNT_OUT_W)'(0),
        r_out.live_count,
        r_out.found_value
    };

endmodule

`default_nettype wire

>>> hw/rtl/kvt_ram.sv
// ----------------------------------------------------------------------------
// kvt_ram
// simple dual-port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module kvt_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned WIDTH = 64,
    parameter int unsigned AW    = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hw/rtl/kvt_ctrl.sv
// ----------------------------------------------------------------------------
// kvt_ctrl
// scan sequencer: walks the live entries, then, where an add or a remove calls for it, updates the memories
// ----------------------------------------------------------------------------
`default_nettype none

module kvt_ctrl
    import kvt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int unsigned IDX_W       = 4,
    parameter int unsigned CNT_W       = 5
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // request
    input  wire logic             i_req_valid,
    output logic                  o_req_ready,
    input  wire logic [OP_W-1:0]  i_op,
    input  wire logic [KEY_W-1:0] i_key,
    input  wire logic [VAL_W-1:0] i_value,
    // response
    output logic                  o_rsp_valid,
    input  wire logic             i_rsp_ready,
    output t_result               o_rsp,
    // memory side
    output logic                  o_key_we,
    output logic                  o_val_we,
    output logic      [IDX_W-1:0] o_waddr,
    output logic      [KEY_W-1:0] o_wkey,
    output logic      [VAL_W-1:0] o_wval,
    output logic      [IDX_W-1:0] o_raddr,
    input  wire logic [KEY_W-1:0] i_rkey,
    input  wire logic [VAL_W-1:0] i_rval
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_ACT  = 3'd2;
    localparam logic [2:0] S_MOVE = 3'd3;
    localparam logic [2:0] S_RESP = 3'd4;

    logic [2:0]       r_state,    n_state;
    logic [CNT_W-1:0] r_count,    n_count;
    logic [CNT_W-1:0] r_ptr,      n_ptr;
    logic             r_pend,     n_pend;
    logic [IDX_W-1:0] r_pend_idx, n_pend_idx;
    logic             r_hit,      n_hit;
    logic [IDX_W-1:0] r_hit_idx,  n_hit_idx;
    logic [OP_W-1:0]  r_op,       n_op;
    logic [KEY_W-1:0] r_key,      n_key;
    logic [VAL_W-1:0] r_val,      n_val;
    logic [ST_W-1:0]  r_status,   n_status;
    logic [VAL_W-1:0] r_found,    n_found;

    logic             issue;
    logic             match;
    logic             full;
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] tail_idx;

    assign issue    = (r_state == S_SCAN) && (r_ptr < r_count);
    assign match    = r_pend && (i_rkey == r_key);
    assign full     = (r_count == CNT_W'(TABLE_DEPTH));
    assign last_idx = IDX_W'(r_count - CNT_W'(1));
    assign tail_idx = r_count[IDX_W-1:0];

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_ptr      = r_ptr;
        n_pend     = r_pend;
        n_pend_idx = r_pend_idx;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_op       = r_op;
        n_key      = r_key;
        n_val      = r_val;
        n_status   = r_status;
        n_found    = r_found;

        o_req_ready = (r_state == S_IDLE);
        o_rsp_valid = 1'b0;
        o_key_we    = 1'b0;
        o_val_we    = 1'b0;
        o_waddr     = r_hit_idx;
        o_wkey      = r_key;
        o_wval      = r_val;
        o_raddr     = r_ptr[IDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_op    = i_op;
                    n_key   = i_key;
                    n_val   = i_value;
                    n_ptr   = '0;
                    n_pend  = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // one read issued and one compare per cycle
                n_pend     = issue;
                n_pend_idx = r_ptr[IDX_W-1:0];
                if (issue) begin
                    n_ptr = r_ptr + CNT_W'(1);
                end
                if (match) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_pend_idx;
                    n_found   = i_rval;
                    n_state   = S_ACT;
                end else if (!issue) begin
                    n_hit   = 1'b0;
                    n_state = S_ACT;
                end
            end
            S_ACT: begin
                n_state  = S_RESP;
                n_status = ST_NOT_FOUND;
                n_found  = '0;
                case (r_op)
                    OP_ADD: begin
                        if (r_hit) begin
                            o_val_we = 1'b1;
                            n_status = ST_REPLACED;
                        end else if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            o_key_we = 1'b1;
                            o_val_we = 1'b1;
                            o_waddr  = tail_idx;
                            n_count  = r_count + CNT_W'(1);
                            n_status = ST_INSERTED;
                        end
                    end
                    OP_REMOVE: begin
                        if (r_hit) begin
                            // fetch the tail entry to fill the hole
                            o_raddr  = last_idx;
                            n_status = ST_REMOVED;
                            n_state  = S_MOVE;
                        end
                    end
                    OP_FIND: begin
                        if (r_hit) begin
                            n_status = ST_FOUND;
                            n_found  = r_found;
                        end
                    end
                    default: begin
                        n_status = ST_NOT_FOUND;
                    end
                endcase
            end
            S_MOVE: begin
                o_key_we = 1'b1;
                o_val_we = 1'b1;
                o_wkey   = i_rkey;
                o_wval   = i_rval;
                n_count  = r_count - CNT_W'(1);
                n_state  = S_RESP;
            end
            S_RESP: begin
                o_rsp_valid = 1'b1;
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_rsp.status      = r_status;
    assign o_rsp.found_value = r_found;
    assign o_rsp.live_count  = CNT_OUT_W'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_pend_idx <= n_pend_idx;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_op       <= n_op;
        r_key      <= n_key;
        r_val      <= n_val;
        r_status   <= n_status;
        r_found    <= n_found;
    end

endmodule

`default_nettype wire

>>> hw/rtl/kvt_checker.sv
// ----------------------------------------------------------------------------
// kvt_checker
// port-level checks of the key/value table, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module kvt_checker
    import kvt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata,
    input wire logic [M_TUSER_W-1:0] m_axis_tuser
);

    logic [VAL_W-1:0]     found_value;
    logic [CNT_OUT_W-1:0] live_count;
    logic                 req_seen;

    assign found_value = m_axis_tdata[VAL_W-1:0];
    assign live_count  = m_axis_tdata[VAL_W +: CNT_OUT_W];
    assign req_seen    = s_axis_tvalid && s_axis_tready;

    // reset leaves no result pending
    `KVT_ASSERT_ALWAYS(a_reset_empties_out, !i_rst_n |=> !m_axis_tvalid)

    // value is reported only by a successful find
    `KVT_ASSERT(a_value_only_on_find,
        m_axis_tvalid && (m_axis_tuser != ST_FOUND) |-> found_value == '0)

    // a full report means the table really holds its depth
    `KVT_ASSERT(a_full_at_depth,
        m_axis_tvalid && (m_axis_tuser == ST_FULL) |-> live_count == CNT_OUT_W'(TABLE_DEPTH))

    // no request is taken in the cycle right after one was taken
    `KVT_ASSERT(a_no_back_to_back, req_seen |=> !s_axis_tready)

    // a stalled result holds
    `KVT_ASSERT(a_out_holds,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind linear_key_value_table_unit kvt_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_kvt_checker (.*);

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the linear key/value table: a clocked driver feeds
// request items from a queue, a shadow table predicts every result at the
// moment its request is accepted, and a clocked monitor compares each result
// item field by field against the oldest prediction
// ----------------------------------------------------------------------------

module tb_top;

    import kvt_pkg::*;

    localparam int unsigned TABLE_DEPTH  = DEF_TABLE_DEPTH;
    localparam int unsigned PAD_W        = M_TDATA_W - VAL_W - CNT_OUT_W;
    localparam int unsigned POOL_SIZE    = 24;
    localparam int unsigned RANDOM_ITEMS = 800;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned HOLD_AFTER   = 120;   // results seen before the long hold-off
    localparam int unsigned HOLD_CYCLES  = 300;

    // the package names three operations, the fourth code must act as a no-op
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // sides of the bus, for the idle pattern state
    localparam int SIDE_SEND = 0;
    localparam int SIDE_RECV = 1;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_table_request;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // request side
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;   // lookup_key, new_value
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;   // operation

    // result side
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;         // found_value, live_count, pad
    logic [M_TUSER_W-1:0] m_axis_tuser;         // status

    linear_key_value_table_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // ------------------------------------------------------------------------
    // shadow table and prediction
    // ------------------------------------------------------------------------
    logic [KEY_W-1:0] shadow_keys [TABLE_DEPTH];
    logic [VAL_W-1:0] shadow_vals [TABLE_DEPTH];
    int unsigned      shadow_count = 0;

    t_table_request   pending_items [$];
    t_result          expected_results [$];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    int unsigned errors = 0;

    // applies one request to the shadow table and returns the result it gives
    function automatic t_result apply_table_op(t_table_request req);
        t_result     res;
        int unsigned hit;
        int unsigned last;
        hit = shadow_count;
        // first live slot wins, so scan downward and keep the lowest match
        for (int i = int'(shadow_count) - 1; i >= 0; i--)
            if (shadow_keys[i] == req.key) hit = unsigned'(i);
        res.status      = ST_NOT_FOUND;
        res.found_value = '0;
        case (req.op)
            OP_ADD: begin
                if (hit < shadow_count) begin
                    shadow_vals[hit] = req.value;
                    res.status = ST_REPLACED;
                end else if (shadow_count >= TABLE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_keys[shadow_count] = req.key;
                    shadow_vals[shadow_count] = req.value;
                    shadow_count++;
                    res.status = ST_INSERTED;
                end
            end
            OP_REMOVE: begin
                if (hit < shadow_count) begin
                    // last live pair moves into the freed slot
                    last = shadow_count - 1;
                    shadow_keys[hit] = shadow_keys[last];
                    shadow_vals[hit] = shadow_vals[last];
                    shadow_count = last;
                    res.status = ST_REMOVED;
                end
            end
            OP_FIND: begin
                if (hit < shadow_count) begin
                    res.found_value = shadow_vals[hit];
                    res.status      = ST_FOUND;
                end
            end
            default: ;  // unused code leaves the table alone
        endcase
        res.live_count = shadow_count[CNT_OUT_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // idle pattern: runs of items with no gaps and runs of random gaps, the kind
    // of each run drawn at random, separately on each side
    // ------------------------------------------------------------------------
    int unsigned run_left [2] = '{0, 0};
    bit          run_busy [2] = '{0, 0};

    function automatic int unsigned draw_gap(int side);
        if (run_left[side] == 0) begin
            run_left[side] = $urandom_range(10, 60);
            run_busy[side] = ($urandom_range(0, 2) == 0);
        end
        run_left[side]--;
        return run_busy[side] ? 0 : $urandom_range(0, 10);
    endfunction

    // ------------------------------------------------------------------------
    // driver: offers the queued items, predicts each one as it is accepted
    // ------------------------------------------------------------------------
    t_table_request item_on_bus;
    int unsigned    send_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap      = 0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            expected_results.push_back(apply_table_op(item_on_bus));
            send_gap = draw_gap(SIDE_SEND);
            if (send_gap == 0 && pending_items.size() != 0) begin
                // back to back, valid stays high
                item_on_bus = pending_items.pop_front();
                s_axis_tdata  <= {item_on_bus.value, item_on_bus.key};
                s_axis_tuser  <= item_on_bus.op;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end else if (!s_axis_tvalid) begin
            if (send_gap != 0) begin
                send_gap--;
            end else if (pending_items.size() != 0) begin
                item_on_bus = pending_items.pop_front();
                s_axis_tdata  <= {item_on_bus.value, item_on_bus.key};
                s_axis_tuser  <= item_on_bus.op;
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // long hold-off of the receiver, so the block backs up and stalls input
    // ------------------------------------------------------------------------
    int unsigned results_seen = 0;
    int unsigned hold_left    = 0;
    bit          hold_done    = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: pulls results with random stalls and checks them
    // ------------------------------------------------------------------------
    int unsigned recv_gap = 0;

    always @(posedge i_clk) begin
        t_result              want;
        logic [ST_W-1:0]      got_status;
        logic [VAL_W-1:0]     got_value;
        logic [CNT_OUT_W-1:0] got_count;
        logic [PAD_W-1:0]     got_pad;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_gap      = 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            {got_pad, got_count, got_value} = m_axis_tdata;
            got_status = m_axis_tuser;
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("result with nothing expected: status %0d value %h count %0d",
                             got_status, got_value, got_count);
            end else begin
                want = expected_results.pop_front();
                if (got_status !== want.status || got_value !== want.found_value ||
                    got_count !== want.live_count || got_pad !== '0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch: expected status %0d value %h count %0d",
                                 want.status, want.found_value, want.live_count);
                        $display("          got status %0d value %h count %0d pad %b",
                                 got_status, got_value, got_count, got_pad);
                    end
                end
            end
            recv_gap = draw_gap(SIDE_RECV);
            m_axis_tready <= (recv_gap == 0) && (hold_left == 0);
        end else if (recv_gap != 0) begin
            recv_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= (hold_left == 0);
        end
    end

    // ------------------------------------------------------------------------
    // run limit
    // ------------------------------------------------------------------------
    int unsigned cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic queue_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                              logic [VAL_W-1:0] value);
        t_table_request req;
        req.op    = op;
        req.key   = key;
        req.value = value;
        pending_items.push_back(req);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) == 0)
            return {$urandom, $urandom};
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    initial begin
        int unsigned      add_share;
        int unsigned      roll;
        logic [OP_W-1:0]  op;

        // pool of keys in pairs that differ in a single bit, so the compare
        // has to look at all 64 bits
        for (int i = 0; i < POOL_SIZE; i += 2) begin
            key_pool[i]     = {$urandom, $urandom};
            key_pool[i + 1] = key_pool[i] ^ (64'd1 << $urandom_range(0, KEY_W - 1));
        end

        // directed part: empty table, extremes of key and value, replace,
        // fill to the top, add to a full table, remove with move of the last
        // entry, and the unused operation code
        queue_item(OP_FIND,   '0, '1);
        queue_item(OP_REMOVE, '0, '0);
        queue_item(OP_UNUSED, '1, '1);
        queue_item(OP_ADD,    '0, '1);
        queue_item(OP_ADD,    '1, '0);
        queue_item(OP_FIND,   '0, '0);
        queue_item(OP_ADD,    '0, 64'h5a5a_a5a5_0f0f_f0f0);
        for (int i = 2; i < TABLE_DEPTH; i++)
            queue_item(OP_ADD, key_pool[i], {$urandom, $urandom});
        queue_item(OP_ADD,    key_pool[TABLE_DEPTH], {$urandom, $urandom});
        queue_item(OP_ADD,    key_pool[5], '1);
        queue_item(OP_REMOVE, '0, '1);
        queue_item(OP_FIND,   key_pool[TABLE_DEPTH - 1], '0);
        queue_item(OP_UNUSED, key_pool[5], '1);

        // random part: the share of adds drifts from chunk to chunk so the
        // table swings between nearly empty and full
        add_share = 40;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0)
                add_share = $urandom_range(20, 70);
            roll = $urandom_range(0, 99);
            if (roll < 4)
                op = OP_UNUSED;
            else if (roll < 4 + add_share)
                op = OP_ADD;
            else if (roll % 2 == 0)
                op = OP_REMOVE;
            else
                op = OP_FIND;
            queue_item(op, pick_key(), {$urandom, $urandom});
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain: everything sent, everything received
        do
            @(negedge i_clk);
        while (pending_items.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
        repeat (TABLE_DEPTH + 8) @(negedge i_clk);

        if (expected_results.size() != 0)
            $display("%0d results never arrived", expected_results.size());
        if (errors == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
